### sv/ttt_pkg.sv
// Tick timer package: payload structs, state and code enums, fixed constants.
// Shared by ttt_serial_unit and tickless_tick_timer; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ttt_pkg;

   // Input and result payloads
   typedef struct packed {
      logic [1:0]          mode;
      logic signed [31:0]  requested_ticks;
   } req_type;

   typedef struct packed {
      logic [31:0] announced_ticks;
      logic [31:0] elapsed_ticks;
      logic [31:0] compare_value;
      logic [63:0] counter_value;
      logic        match_event;
   } rsp_type;

   // Item kinds
   localparam logic [1:0] MODE_COUNT   = 2'd0;
   localparam logic [1:0] MODE_TIMEOUT = 2'd1;
   localparam logic [1:0] MODE_QUERY   = 2'd2;

   // Register indexes
   localparam logic CSR_CPT      = 1'b0;
   localparam logic CSR_TICKLESS = 1'b1;

   // Reset values and limits
   localparam logic [31:0] CPT_RESET     = 32'd10000;
   localparam logic [31:0] COMPARE_RESET = 32'd10000;
   localparam logic [31:0] HALF_RANGE    = 32'h7FFF_FFFF;
   localparam logic [31:0] MIN_LEAD      = 32'd2;

   // Serial arithmetic unit sizing: dividend carries two spare bits for
   // the lead-time round-up numerator.
   localparam int DVD_W     = 34;
   localparam int DIV_STEPS = DVD_W;
   localparam int MUL_STEPS = 32;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   typedef enum logic {
      OP_DIV,
      OP_MUL
   } ser_op_type;

   typedef struct packed {
      logic             start;
      ser_op_type       op;
      logic [DVD_W-1:0] operand_a;
      logic [31:0]      operand_b;
   } ser_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quotient;
      logic [31:0] remainder;
      logic [31:0] product;
   } ser_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_DIV_DT,
      ST_REARM,
      ST_DIV_QUERY,
      ST_DIV_ELAPSED,
      ST_DIV_MAX,
      ST_TARGET,
      ST_MUL,
      ST_LEAD,
      ST_DIV_LEAD,
      ST_ARM,
      ST_DONE,
      ST_REALIGN,
      ST_DIV_REALIGN,
      ST_REALIGN_ARM
   } state_type;

endpackage

`default_nettype wire

### sv/ttt_serial_unit.sv
// Bit-serial arithmetic unit: restoring divider (one quotient bit a cycle)
// and MSB-first shift-add multiplier (low 32 bits). Depends on ttt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ttt_serial_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  ttt_pkg::ser_req_type ser_req,
   output ttt_pkg::ser_rsp_type ser_rsp
);
   import ttt_pkg::*;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   ser_op_type       op_ff, op_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0] shreg_ff, shreg_in;
   logic [31:0]      rem_ff, rem_in;
   logic [31:0]      acc_ff, acc_in;
   logic [31:0]      divisor_ff, divisor_in;

   logic [32:0]      rem_sh;
   logic [33:0]      trial;
   logic             ge;
   logic [CNT_W-1:0] last_step;

   assign rem_sh    = {rem_ff, shreg_ff[DVD_W-1]};
   assign trial     = {1'b0, rem_sh} - {2'b00, divisor_ff};
   assign ge        = ~trial[33];
   assign last_step = (op_ff == OP_DIV) ? CNT_W'(DIV_STEPS - 1) : CNT_W'(MUL_STEPS - 1);

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      op_in      = op_ff;
      cnt_in     = cnt_ff;
      shreg_in   = shreg_ff;
      rem_in     = rem_ff;
      acc_in     = acc_ff;
      divisor_in = divisor_ff;
      if (ser_req.start) begin
         busy_in    = 1'b1;
         op_in      = ser_req.op;
         cnt_in     = '0;
         divisor_in = ser_req.operand_b;
         rem_in     = '0;
         acc_in     = '0;
         if (ser_req.op == OP_DIV) begin
            shreg_in = ser_req.operand_a;
         end else begin
            shreg_in = {ser_req.operand_a[MUL_STEPS-1:0], {(DVD_W-MUL_STEPS){1'b0}}};
         end
      end else if (busy_ff) begin
         case (op_ff)
            OP_DIV: begin
               rem_in   = ge ? trial[31:0] : rem_sh[31:0];
               shreg_in = {shreg_ff[DVD_W-2:0], ge};
            end
            OP_MUL: begin
               acc_in   = {acc_ff[30:0], 1'b0} + (shreg_ff[DVD_W-1] ? divisor_ff : 32'd0);
               shreg_in = {shreg_ff[DVD_W-2:0], 1'b0};
            end
            default: begin
               shreg_in = shreg_ff;
            end
         endcase
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff      <= op_in;
      cnt_ff     <= cnt_in;
      shreg_ff   <= shreg_in;
      rem_ff     <= rem_in;
      acc_ff     <= acc_in;
      divisor_ff <= divisor_in;
   end

   assign ser_rsp.done      = done_ff;
   assign ser_rsp.quotient  = shreg_ff[31:0];
   assign ser_rsp.remainder = rem_ff;
   assign ser_rsp.product   = acc_ff;

endmodule

`default_nettype wire

### sv/tickless_tick_timer.sv
// Tickless tick timer top level: counter, compare and tick bookkeeping with
// a sequencer around one bit-serial divide/multiply unit. Depends on ttt_pkg
// and ttt_serial_unit.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------
//   req     | in        | req_valid/req_ready  | req_data (mode, ticks)
//   rsp     | out       | rsp_valid/rsp_ready  | rsp_data (announce, elapsed,..)
//   csr     | in        | csr_we               | csr_index, csr_wdata
//
// One transaction at a time. A counter item with a compare match and a tickless
// elapsed query each make one divide; a tickless set-timeout makes three or four
// passes through ttt_serial_unit, which works one bit per cycle.
// Reset is synchronous and leaves the block aligned to the CPT_RESET tick size.
// A cycles-per-tick write re-aligns with req_ready low.
// A finished result waits in the output register; the next transaction is
// taken meanwhile and only stalls at its own hand-off.
`timescale 1ns / 1ps
`default_nettype none

module tickless_tick_timer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ttt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ttt_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [31:0]      csr_wdata
);
   import ttt_pkg::*;

   // Architectural state
   state_type   state_ff, state_in;
   logic [63:0] counter_ff, counter_in;
   logic [31:0] compare_ff, compare_in;
   logic [31:0] base_ff, base_in;
   logic [31:0] total_ff, total_in;
   logic [31:0] cpt_ff, cpt_in;
   logic        tickless_ff, tickless_in;

   // Per-transaction working registers
   logic [1:0]  mode_ff, mode_in;
   logic [31:0] raw_ff, raw_in;
   logic [31:0] announced_ff, announced_in;
   logic [31:0] elapsed_ff, elapsed_in;
   logic        match_ff, match_in;
   logic [31:0] el_tmp_ff, el_tmp_in;
   logic [31:0] maxt_ff, maxt_in;
   logic [31:0] span_max_ff, span_max_in;
   logic [31:0] next_ff, next_in;
   logic [33:0] lead_num_ff, lead_num_in;

   // Output register
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   ser_req_type ser_req;
   ser_rsp_type ser_rsp;

   logic [31:0] now;
   logic        accept;
   logic        cpt_write;
   logic        is_match;
   logic [31:0] ticks_req;
   logic [31:0] target;
   logic [31:0] span;
   logic [31:0] lead_gap;
   logic        lead_short;

   // Push a compare that sits less than the minimum lead ahead of now
   // out to now plus the minimum lead.
   function automatic logic [31:0] arm_at(input logic [31:0] tgt, input logic [31:0] cur);
      logic [31:0] diff;
      diff = tgt - cur;
      arm_at = ($signed(diff) < $signed(MIN_LEAD)) ? cur + MIN_LEAD : tgt;
   endfunction

   assign now       = counter_ff[31:0];
   assign req_ready = (state_ff == ST_IDLE) && !csr_we;
   assign accept    = req_valid && req_ready;
   assign cpt_write = csr_we && (csr_index == CSR_CPT);
   assign is_match  = (now == compare_ff);

   // Clamp the requested tick count: forever or too large gives the maximum,
   // negative gives zero, and at least one tick is always asked for.
   always_comb begin
      if (raw_ff == 32'hFFFF_FFFF || (!raw_ff[31] && raw_ff > maxt_ff)) begin
         ticks_req = maxt_ff;
      end else if (raw_ff[31]) begin
         ticks_req = 32'd0;
      end else begin
         ticks_req = raw_ff;
      end
      if (ticks_req == 32'd0) begin
         ticks_req = 32'd1;
      end
   end

   assign target     = total_ff + el_tmp_ff + ticks_req;
   assign span       = ser_rsp.product - base_ff;
   assign lead_gap   = next_ff - now;
   assign lead_short = $signed(lead_gap) < $signed(MIN_LEAD);

   ttt_serial_unit u_serial (
      .clock   (clock),
      .reset   (reset),
      .ser_req (ser_req),
      .ser_rsp (ser_rsp)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (mode_ff)
               MODE_COUNT:   state_in = is_match ? ST_DIV_DT : ST_DONE;
               MODE_TIMEOUT: state_in = tickless_ff ? ST_DIV_ELAPSED : ST_DONE;
               MODE_QUERY:   state_in = tickless_ff ? ST_DIV_QUERY : ST_DONE;
               default:      state_in = ST_DONE;
            endcase
         end
         ST_DIV_DT: begin
            if (ser_rsp.done) begin
               if (ser_rsp.quotient == 32'd0 || !tickless_ff) begin
                  state_in = ST_REARM;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_REARM:       state_in = ST_DONE;
         ST_DIV_QUERY:   state_in = ser_rsp.done ? ST_DONE : ST_DIV_QUERY;
         ST_DIV_ELAPSED: state_in = ser_rsp.done ? ST_DIV_MAX : ST_DIV_ELAPSED;
         ST_DIV_MAX:     state_in = ser_rsp.done ? ST_TARGET : ST_DIV_MAX;
         ST_TARGET:      state_in = ST_MUL;
         ST_MUL:         state_in = ser_rsp.done ? ST_LEAD : ST_MUL;
         ST_LEAD:        state_in = lead_short ? ST_DIV_LEAD : ST_DONE;
         ST_DIV_LEAD:    state_in = ser_rsp.done ? ST_ARM : ST_DIV_LEAD;
         ST_ARM:         state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         ST_REALIGN:     state_in = ST_DIV_REALIGN;
         ST_DIV_REALIGN: state_in = ser_rsp.done ? ST_REALIGN_ARM : ST_DIV_REALIGN;
         ST_REALIGN_ARM: state_in = ST_IDLE;
         default:        state_in = ST_IDLE;
      endcase
      // A cycles-per-tick write restarts the re-alignment from the top.
      if (cpt_write) begin
         state_in = ST_REALIGN;
      end
   end

   // Datapath and outputs
   always_comb begin
      counter_in    = counter_ff;
      compare_in    = compare_ff;
      base_in       = base_ff;
      total_in      = total_ff;
      cpt_in        = cpt_ff;
      tickless_in   = tickless_ff;
      mode_in       = mode_ff;
      raw_in        = raw_ff;
      announced_in  = announced_ff;
      elapsed_in    = elapsed_ff;
      match_in      = match_ff;
      el_tmp_in     = el_tmp_ff;
      maxt_in       = maxt_ff;
      span_max_in   = span_max_ff;
      next_in       = next_ff;
      lead_num_in   = lead_num_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      ser_req.start     = 1'b0;
      ser_req.op        = OP_DIV;
      ser_req.operand_a = {2'b00, now - base_ff};
      ser_req.operand_b = cpt_ff;

      case (state_ff)
         ST_IDLE: begin
            // Take the transaction; a counter item advances the counter now.
            if (accept) begin
               mode_in      = req_data.mode;
               raw_in       = req_data.requested_ticks;
               announced_in = '0;
               elapsed_in   = '0;
               match_in     = 1'b0;
               if (req_data.mode == MODE_COUNT) begin
                  counter_in = counter_ff + 64'd1;
               end
            end
         end
         ST_DECODE: begin
            // Every path out of here that does arithmetic starts with
            // whole ticks since the base.
            case (mode_ff)
               MODE_COUNT: begin
                  if (is_match) begin
                     match_in      = 1'b1;
                     ser_req.start = 1'b1;
                  end
               end
               MODE_TIMEOUT, MODE_QUERY: begin
                  ser_req.start = tickless_ff;
               end
               default: begin
                  ser_req.start = 1'b0;
               end
            endcase
         end
         ST_DIV_DT: begin
            // Advance base by whole ticks: base + dt * cpt is now - remainder.
            if (ser_rsp.done && ser_rsp.quotient != 32'd0) begin
               base_in      = now - ser_rsp.remainder;
               total_in     = total_ff + ser_rsp.quotient;
               announced_in = ser_rsp.quotient;
            end
         end
         ST_REARM: begin
            compare_in = arm_at(base_ff + cpt_ff, now);
         end
         ST_DIV_QUERY: begin
            if (ser_rsp.done) begin
               elapsed_in = ser_rsp.quotient;
            end
         end
         ST_DIV_ELAPSED: begin
            // Hold the elapsed ticks and launch the maximum-ticks divide.
            if (ser_rsp.done) begin
               el_tmp_in         = ser_rsp.quotient;
               ser_req.start     = 1'b1;
               ser_req.operand_a = {2'b00, HALF_RANGE};
            end
         end
         ST_DIV_MAX: begin
            // max_ticks * cpt is the half range less its remainder.
            if (ser_rsp.done) begin
               maxt_in     = ser_rsp.quotient;
               span_max_in = HALF_RANGE - ser_rsp.remainder;
            end
         end
         ST_TARGET: begin
            ser_req.start     = 1'b1;
            ser_req.op        = OP_MUL;
            ser_req.operand_a = {2'b00, target};
         end
         ST_MUL: begin
            // Cap the target to the maximum span beyond the base.
            if (ser_rsp.done) begin
               next_in = (span > span_max_ff) ? base_ff + span_max_ff : ser_rsp.product;
            end
         end
         ST_LEAD: begin
            // Too close: round the shortfall up to whole ticks.
            // ceil(shortfall / cpt) * cpt = (shortfall + cpt - 1) - remainder.
            if (lead_short) begin
               lead_num_in       = {2'b00, cpt_ff} + 34'd1 - {{2{lead_gap[31]}}, lead_gap};
               ser_req.start     = 1'b1;
               ser_req.operand_a = {2'b00, cpt_ff} + 34'd1 - {{2{lead_gap[31]}}, lead_gap};
            end else begin
               compare_in = next_ff;
            end
         end
         ST_DIV_LEAD: begin
            if (ser_rsp.done) begin
               next_in = next_ff + (lead_num_ff[31:0] - ser_rsp.remainder);
            end
         end
         ST_ARM: begin
            compare_in = arm_at(next_ff, now);
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.announced_ticks = announced_ff;
               rsp_data_in.elapsed_ticks   = elapsed_ff;
               rsp_data_in.compare_value   = compare_ff;
               rsp_data_in.counter_value   = counter_ff;
               rsp_data_in.match_event     = match_ff;
            end
         end
         ST_REALIGN: begin
            ser_req.start     = 1'b1;
            ser_req.operand_a = {2'b00, now};
         end
         ST_DIV_REALIGN: begin
            // total = now / cpt; base = total * cpt = now - remainder.
            if (ser_rsp.done) begin
               total_in = ser_rsp.quotient;
               base_in  = now - ser_rsp.remainder;
            end
         end
         ST_REALIGN_ARM: begin
            compare_in = arm_at(base_ff + cpt_ff, now);
         end
         default: begin
            ser_req.start = 1'b0;
         end
      endcase

      if (csr_we) begin
         case (csr_index)
            CSR_CPT: begin
               cpt_in = (csr_wdata == 32'd0) ? 32'd1 : csr_wdata;
            end
            CSR_TICKLESS: begin
               tickless_in = csr_wdata[0];
            end
            default: begin
               tickless_in = tickless_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         counter_ff   <= '0;
         compare_ff   <= COMPARE_RESET;
         base_ff      <= '0;
         total_ff     <= '0;
         cpt_ff       <= CPT_RESET;
         tickless_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         counter_ff   <= counter_in;
         compare_ff   <= compare_in;
         base_ff      <= base_in;
         total_ff     <= total_in;
         cpt_ff       <= cpt_in;
         tickless_ff  <= tickless_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff      <= mode_in;
      raw_ff       <= raw_in;
      announced_ff <= announced_in;
      elapsed_ff   <= elapsed_in;
      match_ff     <= match_in;
      el_tmp_ff    <= el_tmp_in;
      maxt_ff      <= maxt_in;
      span_max_ff  <= span_max_in;
      next_ff      <= next_in;
      lead_num_ff  <= lead_num_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // A counter transaction advances the counter by exactly one.
   a_counter_step: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.mode == MODE_COUNT |=> counter_ff == $past(counter_ff) + 64'd1)
      else $error("counter did not advance by one");

   // A cycles-per-tick write never leaves a zero divisor and starts re-alignment.
   a_cpt_write: assert property (@(posedge clock) disable iff (reset)
      cpt_write |=> cpt_ff != 32'd0 && state_ff == ST_REALIGN)
      else $error("cycles-per-tick write mishandled");

   // A finished transaction lands in the output register and the sequencer idles.
   a_handoff: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE && (!rsp_valid_ff || rsp_ready) && !cpt_write
      |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("result hand-off lost");
`endif

endmodule

`default_nettype wire

### verif/testbench.sv
// Self-checking testbench for tickless_tick_timer: directed and random transactions,
// each result checked against a transaction-level tick timer model kept here.
// Depends on ttt_pkg and the tickless_tick_timer RTL only.
`timescale 1ns / 1ps

module testbench;
   import ttt_pkg::*;

   // Mode code 3 has no name in the package; the block must treat it as a no-op.
   localparam logic [1:0]  MODE_UNUSED = 2'd3;
   localparam int unsigned CYCLE_LIMIT = 1_500_000;
   localparam int unsigned END_SETTLE  = 200;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we    = 1'b0;
   logic        csr_index = CSR_CPT;
   logic [31:0] csr_wdata = '0;

   tickless_tick_timer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 12 ns period: low half first, then high.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Timer model: counter, armed compare, tick bookkeeping and registers.
   // ---------------------------------------------------------------------
   logic [63:0] free_cnt;
   logic [31:0] armed_cmp;
   logic [31:0] tick_base;
   logic [31:0] tick_count;
   logic [31:0] tick_cycles;
   logic        tickless_on;

   // Results owed by the block, oldest first.
   rsp_type     pending_timer_rsps[$];
   rsp_type     oldest_rsp;

   int unsigned error_count    = 0;
   int unsigned cycle_count    = 0;
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;

   // Arm the compare, but never closer than the minimum lead ahead of now.
   function automatic void arm_compare_at(input logic [31:0] target);
      logic [31:0]        now_lo;
      logic signed [31:0] lead;
      now_lo = free_cnt[31:0];
      lead   = target - now_lo;
      if (lead < $signed(MIN_LEAD)) armed_cmp = now_lo + MIN_LEAD;
      else                          armed_cmp = target;
   endfunction

   // Snap the bookkeeping to the last whole tick and arm one tick ahead.
   function automatic void realign_ticks();
      tick_count = free_cnt[31:0] / tick_cycles;
      tick_base  = tick_count * tick_cycles;
      arm_compare_at(tick_base + tick_cycles);
   endfunction

   function automatic void reset_timer_model();
      free_cnt    = '0;
      tick_cycles = CPT_RESET;
      tickless_on = 1'b1;
      realign_ticks();
   endfunction

   // Set-timeout: clamp the request, cap the target, then enforce the lead.
   function automatic void arm_timeout(input logic [31:0] raw);
      logic [31:0]        now_lo, elapsed, tick_limit, ticks, next_cmp, span;
      logic signed [31:0] req_s, ahead;
      logic signed [63:0] gap;
      logic [63:0]        cpt_wide, steps, step_cycles;
      now_lo     = free_cnt[31:0];
      elapsed    = (now_lo - tick_base) / tick_cycles;
      tick_limit = HALF_RANGE / tick_cycles;
      req_s      = raw;
      if (req_s == -1)           ticks = tick_limit;
      else if (req_s < 0)        ticks = '0;
      else if (raw > tick_limit) ticks = tick_limit;
      else                       ticks = raw;
      if (ticks == 0) ticks = 32'd1;

      next_cmp = (tick_count + elapsed + ticks) * tick_cycles;
      span     = tick_limit * tick_cycles;
      if ((next_cmp - tick_base) > span) next_cmp = tick_base + span;

      // Too close: add whole ticks in one step to clear the minimum lead.
      ahead = next_cmp - now_lo;
      if (ahead < $signed(MIN_LEAD)) begin
         gap         = 64'sd2 - ahead;
         cpt_wide    = {32'd0, tick_cycles};
         steps       = ($unsigned(gap) + cpt_wide - 64'd1) / cpt_wide;
         step_cycles = steps * cpt_wide;
         next_cmp    = next_cmp + step_cycles[31:0];
      end
      arm_compare_at(next_cmp);
   endfunction

   // Advance the model by one transaction and return the result it owes.
   function automatic rsp_type tick_timer_step(input req_type item);
      rsp_type     r;
      logic [31:0] whole;
      r = '0;
      case (item.mode)
         MODE_COUNT: begin
            free_cnt = free_cnt + 64'd1;
            if (free_cnt[31:0] == armed_cmp) begin
               whole         = (free_cnt[31:0] - tick_base) / tick_cycles;
               r.match_event = 1'b1;
               if (whole == 0) begin
                  // Early match: nothing to announce, re-arm one tick past base.
                  arm_compare_at(tick_base + tick_cycles);
               end else begin
                  tick_base         = tick_base + whole * tick_cycles;
                  tick_count        = tick_count + whole;
                  r.announced_ticks = whole;
                  if (!tickless_on) arm_compare_at(tick_base + tick_cycles);
               end
            end
         end
         MODE_TIMEOUT: begin
            if (tickless_on) arm_timeout(item.requested_ticks);
         end
         MODE_QUERY: begin
            if (tickless_on) r.elapsed_ticks = (free_cnt[31:0] - tick_base) / tick_cycles;
         end
         default: begin
            // Unused code: state stays, result reports it.
         end
      endcase
      r.compare_value = armed_cmp;
      r.counter_value = free_cnt;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Result side: random back-pressure and the checker.
   // ---------------------------------------------------------------------
   always @(negedge clock) rsp_ready <= ($urandom_range(99) >= recv_stall_pct);

   task automatic report_field(input string field, input logic [63:0] want_v,
                               input logic [63:0] got_v);
      error_count++;
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h",
               $time, field, want_v, got_v);
   endtask

   // Sample at the rising edge, before the block's own updates land.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_timer_rsps.size() == 0) begin
            report_field("unexpected transaction, counter", 64'd0, rsp_data.counter_value);
         end else begin
            oldest_rsp = pending_timer_rsps.pop_front();
            if (rsp_data.announced_ticks !== oldest_rsp.announced_ticks)
               report_field("announced_ticks", oldest_rsp.announced_ticks,
                            rsp_data.announced_ticks);
            if (rsp_data.elapsed_ticks !== oldest_rsp.elapsed_ticks)
               report_field("elapsed_ticks", oldest_rsp.elapsed_ticks,
                            rsp_data.elapsed_ticks);
            if (rsp_data.compare_value !== oldest_rsp.compare_value)
               report_field("compare_value", oldest_rsp.compare_value,
                            rsp_data.compare_value);
            if (rsp_data.counter_value !== oldest_rsp.counter_value)
               report_field("counter_value", oldest_rsp.counter_value,
                            rsp_data.counter_value);
            if (rsp_data.match_event !== oldest_rsp.match_event)
               report_field("match_event", oldest_rsp.match_event, rsp_data.match_event);
         end
      end
   end

   // Watchdog: end the run if the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Request side. Every task starts and ends just after a falling edge.
   // ---------------------------------------------------------------------

   // Send one transaction after any random idle gap; valid stays high afterwards
   // so back-to-back items with no idle gap never drop it for a single step.
   task automatic send_item(input logic [1:0] mode, input logic [31:0] ticks);
      req_type item;
      item.mode            = mode;
      item.requested_ticks = ticks;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      pending_timer_rsps.push_back(tick_timer_step(item));
      @(negedge clock);
   endtask

   // Drop valid and hold until every owed result has come back.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (pending_timer_rsps.size() != 0) @(negedge clock);
   endtask

   // One-cycle register write pulse, then release; caller has drained.
   task automatic write_csr(input logic idx, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_CPT) begin
         tick_cycles = (value == 0) ? 32'd1 : value;
         realign_ticks();
      end else begin
         tickless_on = value[0];
      end
      @(negedge clock);
   endtask

   // Mode bit with random upper bits; the block must ignore them.
   function automatic logic [31:0] mode_word(input logic tickless);
      logic [31:0] w;
      w    = $urandom;
      w[0] = tickless;
      return w;
   endfunction

   // Mostly counter steps so compares are actually reached, with timeouts
   // biased to short counts and a sprinkling of clamps and full-range values.
   task automatic send_random_item();
      logic [1:0]  mode;
      logic [31:0] ticks;
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 60)      mode = MODE_COUNT;
      else if (pick < 80) mode = MODE_TIMEOUT;
      else if (pick < 95) mode = MODE_QUERY;
      else                mode = MODE_UNUSED;
      pick = $urandom_range(99);
      if (pick < 50)      ticks = $urandom_range(12);
      else if (pick < 60) ticks = 32'hFFFF_FFFF;
      else if (pick < 70) ticks = 32'hFFFF_FFFE - $urandom_range(4);
      else if (pick < 80) begin
         case ($urandom_range(2))
            0:       ticks = 32'h7FFF_FFFF;
            1:       ticks = 32'h8000_0000;
            default: ticks = 32'd0;
         endcase
      end else begin
         ticks = $urandom;
      end
      send_item(mode, ticks);
   endtask

   task automatic run_random_phase(input int unsigned n_items, input logic [31:0] cpt,
                                   input logic tickless, input int unsigned idle_pct,
                                   input int unsigned stall_pct);
      wait_for_drain();
      // Tickless first: the cycles-per-tick write starts a realign.
      write_csr(CSR_TICKLESS, mode_word(tickless));
      write_csr(CSR_CPT, cpt);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (int unsigned i = 0; i < n_items; i++) begin
         // Halfway, hold off until the block has emptied out.
         if (i == n_items / 2) wait_for_drain();
         send_random_item();
      end
      wait_for_drain();
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Reset defaults: query, unused code, and every timeout clamp at the CPT_RESET tick size.
   task automatic test_reset_defaults();
      send_item(MODE_QUERY,   32'd0);
      send_item(MODE_UNUSED,  32'hFFFF_FFFF);
      send_item(MODE_TIMEOUT, 32'hFFFF_FFFF);   // forever
      send_item(MODE_TIMEOUT, 32'h7FFF_FFFF);   // above the maximum
      send_item(MODE_TIMEOUT, 32'h8000_0000);   // most negative
      send_item(MODE_TIMEOUT, 32'd0);
      send_item(MODE_TIMEOUT, 32'd5);
   endtask

   // Zero written as cycles per tick becomes one: matches, announces and
   // the lead round-up all happen within a few counter steps.
   task automatic test_unit_tick();
      wait_for_drain();
      write_csr(CSR_CPT, 32'd0);
      send_item(MODE_COUNT,   32'd0);
      send_item(MODE_COUNT,   32'd0);
      send_item(MODE_COUNT,   32'd0);
      send_item(MODE_QUERY,   32'd0);
      send_item(MODE_TIMEOUT, 32'd1);
      wait_for_drain();
      send_item(MODE_COUNT,   32'd0);
      send_item(MODE_COUNT,   32'd0);
      send_item(MODE_TIMEOUT, 32'hFFFF_FFFE);
   endtask

   // Huge ticks: early matches with nothing to announce, zero maximum,
   // and round-up steps that fall short of the lead.
   task automatic test_wide_tick();
      wait_for_drain();
      write_csr(CSR_CPT, 32'hFFFF_FFFF);
      send_item(MODE_COUNT,   32'd0);
      send_item(MODE_COUNT,   32'd0);
      send_item(MODE_TIMEOUT, 32'd3);
      wait_for_drain();
      write_csr(CSR_CPT, 32'h8000_0000);
      send_item(MODE_TIMEOUT, 32'd1);
      wait_for_drain();
      write_csr(CSR_CPT, 32'h7FFF_FFFE);
      send_item(MODE_TIMEOUT, 32'hFFFF_FFFF);
      send_item(MODE_COUNT,   32'd0);
      wait_for_drain();
      write_csr(CSR_CPT, 32'h7FFF_FFFF);
      send_item(MODE_TIMEOUT, 32'd100);
   endtask

   // Periodic mode: timeouts and queries do nothing, every match re-arms.
   task automatic test_periodic_rearm();
      wait_for_drain();
      write_csr(CSR_TICKLESS, mode_word(1'b0));
      write_csr(CSR_CPT, 32'd2);
      send_item(MODE_TIMEOUT, 32'd4);
      send_item(MODE_COUNT,   32'd0);
      send_item(MODE_COUNT,   32'd0);
      send_item(MODE_QUERY,   32'd0);
   endtask

   // Random traffic across tick sizes, both modes and a range of idle and stall patterns.
   task automatic test_random_traffic();
      run_random_phase(200, 32'd1,          1'b1, 0,  0);
      run_random_phase(250, 32'd7,          1'b1, 69, 0);
      run_random_phase(200, 32'd3,          1'b0, 0,  69);
      run_random_phase(250, 32'd13,         1'b1, 8,  8);
      run_random_phase(100, 32'hFFFF_FFFF,  1'b1, 8,  8);
      run_random_phase(100, 32'h7FFF_FFFF,  1'b1, 0,  0);
      run_random_phase(150, 32'd2,          1'b0, 8,  8);
   endtask

   initial begin
      reset_timer_model();
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_unit_tick();
      test_wide_tick();
      test_periodic_rearm();
      test_random_traffic();

      // Let any stray result show up before the verdict.
      wait_for_drain();
      repeat (END_SETTLE) @(negedge clock);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
